// ----- hw/rtl/gaussian_covariance_from_scale_rotation_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the Gaussian covariance block
// Shared property forms used by the block's concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_COVARIANCE_FROM_SCALE_ROTATION_DEFINES_SVH
`define GAUSSIAN_COVARIANCE_FROM_SCALE_ROTATION_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define GCOV_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define GCOV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/gcov_pkg.sv -----
// ----------------------------------------------------------------------------
// gcov_pkg
// Types, fixed-point widths and constants of the Gaussian covariance pipeline.
// ----------------------------------------------------------------------------
package gcov_pkg;

  // Field and intermediate widths.
  localparam int SCALE_W    = 24;  // Q8.16 scale
  localparam int QUAT_W     = 16;  // Q1.15 quaternion component
  localparam int QPROD_W    = 32;  // qa*qb, read as 2*qa*qb in Q.29
  localparam int ROT_W      = 33;  // rotation entry, Q.29
  localparam int TPROD_W    = 57;  // R*s, Q.45
  localparam int FRAC_SHIFT = 29;  // Q.45 to Q.16
  localparam int TERM_W     = 28;  // T entry, Q.16
  localparam int CPROD_W    = 56;  // T*T, Q.32
  localparam int CSUM_W     = 58;  // sum of three products
  localparam int COV_W      = 48;  // covariance output, Q16.32

  typedef logic signed [SCALE_W-1:0] scale_t;
  typedef logic signed [QUAT_W-1:0]  quat_t;
  typedef logic signed [QPROD_W-1:0] qprod_t;
  typedef logic signed [ROT_W-1:0]   rot_t;
  typedef logic signed [TPROD_W-1:0] tprod_t;
  typedef logic signed [TERM_W-1:0]  term_t;
  typedef logic signed [CPROD_W-1:0] cprod_t;
  typedef logic signed [CSUM_W-1:0]  csum_t;
  typedef logic signed [COV_W-1:0]   cov_t;

  typedef struct packed {
    quat_t x;
    quat_t y;
    quat_t z;
    quat_t w;
  } quat_vec_t;

  // One in Q.29, and the half-LSB bias for rounding Q.45 down to Q.16.
  localparam rot_t   ROT_ONE  = rot_t'(1) <<< FRAC_SHIFT;
  localparam tprod_t RND_BIAS = tprod_t'(1) <<< (FRAC_SHIFT - 1);

  // Saturation bounds of the output, held at the sum width.
  localparam csum_t COV_MAX = (csum_t'(1) <<< (COV_W - 1)) - csum_t'(1);
  localparam csum_t COV_MIN = ~COV_MAX;

  // Clamp a covariance sum to the output range.
  function automatic cov_t sat_cov(input csum_t c);
    cov_t r;
    if (c > COV_MAX) begin
      r = COV_MAX[COV_W-1:0];
    end else if (c < COV_MIN) begin
      r = COV_MIN[COV_W-1:0];
    end else begin
      r = c[COV_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/gcov_quat_rot.sv -----
// ----------------------------------------------------------------------------
// gcov_quat_rot
// Two pipeline stages: quaternion products, then the rotation matrix in Q.29.
// ----------------------------------------------------------------------------
module gcov_quat_rot (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  gcov_pkg::scale_t   scale_in [3],
  input  gcov_pkg::quat_vec_t quat,
  output logic               out_valid,
  input  logic               out_ready,
  output gcov_pkg::rot_t     rot [9],
  output gcov_pkg::scale_t   scale_out [3]
);
  import gcov_pkg::*;

  logic   v1, v2;
  logic   en1, en2;
  qprod_t xx, yy, zz, xy, xz, yz, wx, wy, wz;
  scale_t scale1 [3];

  // A stage loads when it is empty or its successor loads this cycle.
  assign en2       = !v2 || out_ready;
  assign en1       = !v1 || en2;
  assign in_ready  = en1;
  assign out_valid = v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
    end
  end

  // Stage 1: the nine quaternion products.
  always_ff @(posedge clk) begin
    if (en1) begin
      xx <= qprod_t'(quat.x) * qprod_t'(quat.x);
      yy <= qprod_t'(quat.y) * qprod_t'(quat.y);
      zz <= qprod_t'(quat.z) * qprod_t'(quat.z);
      xy <= qprod_t'(quat.x) * qprod_t'(quat.y);
      xz <= qprod_t'(quat.x) * qprod_t'(quat.z);
      yz <= qprod_t'(quat.y) * qprod_t'(quat.z);
      wx <= qprod_t'(quat.w) * qprod_t'(quat.x);
      wy <= qprod_t'(quat.w) * qprod_t'(quat.y);
      wz <= qprod_t'(quat.w) * qprod_t'(quat.z);
      for (int i = 0; i < 3; i++) scale1[i] <= scale_in[i];
    end
  end

  // Stage 2: rotation entries, row major; sums are formed at the full Q.29 width.
  always_ff @(posedge clk) begin
    if (en2) begin
      rot[0] <= ROT_ONE - (rot_t'(yy) + rot_t'(zz));
      rot[1] <= rot_t'(xy) - rot_t'(wz);
      rot[2] <= rot_t'(xz) + rot_t'(wy);
      rot[3] <= rot_t'(xy) + rot_t'(wz);
      rot[4] <= ROT_ONE - (rot_t'(xx) + rot_t'(zz));
      rot[5] <= rot_t'(yz) - rot_t'(wx);
      rot[6] <= rot_t'(xz) - rot_t'(wy);
      rot[7] <= rot_t'(yz) + rot_t'(wx);
      rot[8] <= ROT_ONE - (rot_t'(xx) + rot_t'(yy));
      for (int i = 0; i < 3; i++) scale_out[i] <= scale1[i];
    end
  end

endmodule

// ----- hw/rtl/gcov_scale_mul.sv -----
// ----------------------------------------------------------------------------
// gcov_scale_mul
// Two pipeline stages: T = R * diag(scale) in Q.45, then round half up to Q.16.
// ----------------------------------------------------------------------------
module gcov_scale_mul (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  gcov_pkg::rot_t   rot [9],
  input  gcov_pkg::scale_t scale [3],
  output logic             out_valid,
  input  logic             out_ready,
  output gcov_pkg::term_t  term [9]
);
  import gcov_pkg::*;

  logic   v1, v2;
  logic   en1, en2;
  tprod_t prod [9];
  tprod_t biased [9];

  assign en2       = !v2 || out_ready;
  assign en1       = !v1 || en2;
  assign in_ready  = en1;
  assign out_valid = v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
    end
  end

  // Stage 3: each entry scaled by the scale of its column.
  always_ff @(posedge clk) begin
    if (en1) begin
      for (int k = 0; k < 9; k++) begin
        prod[k] <= tprod_t'(rot[k]) * tprod_t'(scale[k % 3]);
      end
    end
  end

  // Adding the half LSB before the arithmetic shift rounds half up to Q.16.
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      biased[k] = prod[k] + RND_BIAS;
    end
  end

  // Stage 4: rounded T entries.
  always_ff @(posedge clk) begin
    if (en2) begin
      for (int k = 0; k < 9; k++) begin
        term[k] <= biased[k][FRAC_SHIFT +: TERM_W];
      end
    end
  end

endmodule

// ----- hw/rtl/gcov_cov_acc.sv -----
// ----------------------------------------------------------------------------
// gcov_cov_acc
// Two pipeline stages: the row products of T, then sums and saturation.
// ----------------------------------------------------------------------------
module gcov_cov_acc (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  gcov_pkg::term_t term [9],
  output logic            out_valid,
  input  logic            out_ready,
  output gcov_pkg::cov_t  cov [6]
);
  import gcov_pkg::*;

  // Row pairs of the six distinct entries: xx, xy, xz, yy, yz, zz.
  localparam int ROW_A [6] = '{0, 0, 0, 1, 1, 2};
  localparam int ROW_B [6] = '{0, 1, 2, 1, 2, 2};

  logic   v1, v2;
  logic   en1, en2;
  cprod_t cp [18];
  csum_t  csum [6];

  assign en2       = !v2 || out_ready;
  assign en1       = !v1 || en2;
  assign in_ready  = en1;
  assign out_valid = v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
    end
  end

  // Stage 5: the three products of every entry.
  always_ff @(posedge clk) begin
    if (en1) begin
      for (int k = 0; k < 6; k++) begin
        for (int j = 0; j < 3; j++) begin
          cp[k*3 + j] <= cprod_t'(term[ROW_A[k]*3 + j]) * cprod_t'(term[ROW_B[k]*3 + j]);
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      csum[k] = csum_t'(cp[k*3]) + csum_t'(cp[k*3 + 1]) + csum_t'(cp[k*3 + 2]);
    end
  end

  // Stage 6: saturated covariance entries.
  always_ff @(posedge clk) begin
    if (en2) begin
      for (int k = 0; k < 6; k++) begin
        cov[k] <= sat_cov(csum[k]);
      end
    end
  end

endmodule

// ----- hw/rtl/gaussian_covariance_from_scale_rotation.sv -----
// ----------------------------------------------------------------------------
// gaussian_covariance_from_scale_rotation
// Covariance of a 3D Gaussian from its axis scales and rotation quaternion.
// ----------------------------------------------------------------------------
// Usage:
//   One Gaussian arrives per transfer on the s_ channel: three Q8.16 scales
//   and a Q1.15 quaternion (x, y, z, w), used without normalization. Each
//   one yields exactly one transfer on the m_ channel with the six distinct
//   entries of R*S*S*R^T in Q16.32, each clamped to the 48-bit range.
//   The datapath is a six-stage pipeline: quaternion products, rotation
//   matrix, column scaling, rounding to Q.16, row products, sums with
//   saturation. Throughput is one Gaussian per cycle while m_tready does
//   not stall the output; the widest step is the 33x24 column-scaling
//   multiply.
//   Every stage holds its own valid bit and loads when it is empty or its
//   successor moves, so a stall on m_tready backs up one stage at a time and
//   bubbles are squeezed out; s_tready drops only once all six stages hold
//   data. Items are never dropped or duplicated.
//   Synchronous reset empties the pipeline; no configuration exists.
// ----------------------------------------------------------------------------
`include "gaussian_covariance_from_scale_rotation_defines.svh"

module gaussian_covariance_from_scale_rotation (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // scale_x[23:0], scale_y[47:24], scale_z[71:48], quat_x[87:72],
  // quat_y[103:88], quat_z[119:104], quat_w[135:120]
  input  logic [135:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // cov_xx[47:0], cov_xy[95:48], cov_xz[143:96], cov_yy[191:144],
  // cov_yz[239:192], cov_zz[287:240]
  output logic [287:0] m_tdata
);
  import gcov_pkg::*;

  scale_t    scale_in [3];
  quat_vec_t quat;
  rot_t      rot [9];
  scale_t    scale_rot [3];
  term_t     term [9];
  cov_t      cov [6];
  logic      rot_valid, rot_ready;
  logic      term_valid, term_ready;

  // Unpack the input transfer.
  assign scale_in[0] = s_tdata[23:0];
  assign scale_in[1] = s_tdata[47:24];
  assign scale_in[2] = s_tdata[71:48];
  assign quat.x      = s_tdata[87:72];
  assign quat.y      = s_tdata[103:88];
  assign quat.z      = s_tdata[119:104];
  assign quat.w      = s_tdata[135:120];

  gcov_quat_rot u_quat_rot (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .scale_in  (scale_in),
    .quat      (quat),
    .out_valid (rot_valid),
    .out_ready (rot_ready),
    .rot       (rot),
    .scale_out (scale_rot)
  );

  gcov_scale_mul u_scale_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rot_valid),
    .in_ready  (rot_ready),
    .rot       (rot),
    .scale     (scale_rot),
    .out_valid (term_valid),
    .out_ready (term_ready),
    .term      (term)
  );

  gcov_cov_acc u_cov_acc (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (term_valid),
    .in_ready  (term_ready),
    .term      (term),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cov       (cov)
  );

  // Pack the output transfer.
  assign m_tdata = {cov[5], cov[4], cov[3], cov[2], cov[1], cov[0]};

  // The pipeline comes out of reset empty.
  `GCOV_ASSERT_SAME(a_empty_after_reset, clk, rst, $past(rst), !m_tvalid, "output valid right after reset")

  // With the last stage free to move, every stage can load, so input is open.
  `GCOV_ASSERT_SAME(a_ready_when_free, clk, rst, m_tready || !m_tvalid, s_tready, "input blocked with a free pipeline")

  // Diagonal entries are sums of squares and never negative.
  `GCOV_ASSERT_SAME(a_diag_nonneg, clk, rst, m_tvalid, !m_tdata[47] && !m_tdata[191] && !m_tdata[287], "negative diagonal covariance entry")

  // With the input blocked and no space downstream, a result is still offered next cycle.
  `GCOV_ASSERT_NEXT(a_full_holds, clk, rst, !s_tready && !m_tready, m_tvalid, "input blocked with no result waiting")

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// Testbench for gaussian_covariance_from_scale_rotation
// Streams Gaussians (scales and quaternion) into the block and compares each
// covariance transfer on the output stream with a local fixed-point predictor
// or a table value, under bursty input and a receiver with its own stalls.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gcov_pkg::*;

  // One Gaussian as it travels on s_tdata, highest field first.
  typedef struct packed {
    quat_t  quat_w;
    quat_t  quat_z;
    quat_t  quat_y;
    quat_t  quat_x;
    scale_t scale_z;
    scale_t scale_y;
    scale_t scale_x;
  } gauss_t;

  // One covariance result as it travels on m_tdata, highest field first.
  typedef struct packed {
    cov_t cov_zz;
    cov_t cov_yz;
    cov_t cov_yy;
    cov_t cov_xz;
    cov_t cov_xy;
    cov_t cov_xx;
  } cov_result_t;

  // A row of the directed table; typed rows carry their own expectation.
  typedef struct {
    gauss_t      item;
    bit          typed;
    cov_result_t exp;
  } stim_row_t;

  // Receiver stall patterns.
  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  localparam longint ONE_Q29   = longint'(1) << 29;
  localparam longint HALF_LSB  = longint'(1) << 28;
  localparam longint COV_HI    = (longint'(1) << 47) - 1;
  localparam longint COV_LO    = -(longint'(1) << 47);
  localparam int     RANDOM_N  = 1135;
  localparam int     LIMIT     = 300000;
  localparam int     HOLD_LEN  = 400;
  localparam int     DRAIN_LEN = 16;
  localparam int     REPORT_N  = 10;

  localparam cov_t C_MAX  = 48'h7FFF_FFFF_FFFF;
  localparam cov_t C_MIN  = 48'h8000_0000_0000;
  localparam cov_t C_ONE  = 48'h0001_0000_0000;
  localparam cov_t C_BIG  = 48'd70368727400449;
  localparam cov_t C_NEG  = 48'h4000_0000_0000;

  logic         clk = 1'b0;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [135:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [287:0] m_tdata;

  cov_result_t pending_cov[$];
  stim_row_t   directed_rows[$];
  int          mismatch_count = 0;
  int          accepted_in = 0;
  int          burst_left = 0;
  int          cycle_count = 0;
  string       cov_name[6] = '{"cov_xx", "cov_xy", "cov_xz", "cov_yy", "cov_yz", "cov_zz"};

  gaussian_covariance_from_scale_rotation dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // Expected covariance of one Gaussian, in 64-bit integer arithmetic.
  function automatic cov_result_t covariance_of(input gauss_t g);
    longint s[3];
    longint rot[3][3];
    longint term[3][3];
    longint qx, qy, qz, qw;
    longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
    longint c;
    int     ra[6] = '{0, 0, 0, 1, 1, 2};
    int     rb[6] = '{0, 1, 2, 1, 2, 2};
    logic [287:0] packed_out;
    s[0] = longint'(signed'(g.scale_x));
    s[1] = longint'(signed'(g.scale_y));
    s[2] = longint'(signed'(g.scale_z));
    qx = longint'(signed'(g.quat_x));
    qy = longint'(signed'(g.quat_y));
    qz = longint'(signed'(g.quat_z));
    qw = longint'(signed'(g.quat_w));
    // Products of Q1.15 values are read as twice the product in Q.29.
    xx = qx * qx; yy = qy * qy; zz = qz * qz;
    xy = qx * qy; xz = qx * qz; yz = qy * qz;
    wx = qw * qx; wy = qw * qy; wz = qw * qz;
    rot[0][0] = ONE_Q29 - (yy + zz);
    rot[0][1] = xy - wz;
    rot[0][2] = xz + wy;
    rot[1][0] = xy + wz;
    rot[1][1] = ONE_Q29 - (xx + zz);
    rot[1][2] = yz - wx;
    rot[2][0] = xz - wy;
    rot[2][1] = yz + wx;
    rot[2][2] = ONE_Q29 - (xx + yy);
    // Scale the columns and round Q.45 to Q.16, half up.
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        term[i][j] = (rot[i][j] * s[j] + HALF_LSB) >>> 29;
      end
    end
    // Row dot products with clamping to the 48-bit output.
    for (int k = 0; k < 6; k++) begin
      c = term[ra[k]][0] * term[rb[k]][0] + term[ra[k]][1] * term[rb[k]][1] +
          term[ra[k]][2] * term[rb[k]][2];
      if (c > COV_HI) begin
        c = COV_HI;
      end else if (c < COV_LO) begin
        c = COV_LO;
      end
      packed_out[k*COV_W +: COV_W] = c[COV_W-1:0];
    end
    return cov_result_t'(packed_out);
  endfunction

  function automatic gauss_t mk_gauss(input int sx, input int sy, input int sz,
                                      input int qx, input int qy, input int qz,
                                      input int qw);
    gauss_t g;
    g.scale_x = scale_t'(sx);
    g.scale_y = scale_t'(sy);
    g.scale_z = scale_t'(sz);
    g.quat_x  = quat_t'(qx);
    g.quat_y  = quat_t'(qy);
    g.quat_z  = quat_t'(qz);
    g.quat_w  = quat_t'(qw);
    return g;
  endfunction

  function automatic scale_t rand_scale();
    scale_t v;
    case ($urandom_range(0, 3))
      0: v = scale_t'($urandom);
      1, 2: v = scale_t'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
      default: begin
        case ($urandom_range(0, 4))
          0: v = scale_t'(8388607);
          1: v = scale_t'(-8388608);
          2: v = scale_t'(0);
          3: v = scale_t'(1);
          default: v = scale_t'(-1);
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic quat_t rand_quat(input int mode);
    quat_t v;
    case (mode)
      0: v = quat_t'($urandom);
      1: v = quat_t'(int'($urandom_range(0, 46340)) - 23170);
      2: begin
        case ($urandom_range(0, 3))
          0: v = quat_t'(32767);
          1: v = quat_t'(-32768);
          2: v = quat_t'(0);
          default: v = quat_t'($urandom);
        endcase
      end
      default: v = ($urandom_range(0, 1) == 0) ? quat_t'(0) : quat_t'($urandom);
    endcase
    return v;
  endfunction

  function automatic gauss_t rand_gaussian();
    gauss_t g;
    int     qmode;
    qmode = $urandom_range(0, 3);
    g.scale_x = rand_scale();
    g.scale_y = rand_scale();
    g.scale_z = rand_scale();
    g.quat_x  = rand_quat(qmode);
    g.quat_y  = rand_quat(qmode);
    g.quat_z  = rand_quat(qmode);
    g.quat_w  = rand_quat(qmode);
    return g;
  endfunction

  // Offer one Gaussian in bursts with random gaps, and record its expectation
  // once the transfer has happened. Called and returning at a falling edge.
  task automatic send_gaussian(input gauss_t g, input cov_result_t exp_val);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= g;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_cov.push_back(exp_val);
    accepted_in++;
    @(negedge clk);
  endtask

  // Receiver: stall patterns that change on a random timer, and one long
  // hold-off so the pipeline fills up and blocks its input.
  rx_mode_t rx_mode = RX_ALWAYS;
  int       rx_timer = 0;
  int       hold_left = 0;
  bit       hold_done = 1'b0;

  always @(negedge clk) begin
    if (rx_timer == 0) begin
      rx_mode  = rx_mode_t'($urandom_range(0, 3));
      rx_timer = $urandom_range(16, 96);
    end else begin
      rx_timer--;
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!hold_done && accepted_in >= 300) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN - 1;
      m_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS:   m_tready <= 1'b1;
        RX_RANDOM:   m_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
        default:     m_tready <= (rx_timer[1:0] != 2'b00);
      endcase
    end
  end

  // Compare every output transfer with the oldest expectation.
  always @(posedge clk) begin
    cov_result_t exp_val;
    cov_t        got_f, exp_f;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_cov.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_N) begin
          $display("[%0t] unexpected covariance transfer %h", $realtime, m_tdata);
        end
      end else begin
        exp_val = pending_cov.pop_front();
        for (int k = 0; k < 6; k++) begin
          got_f = m_tdata[k*COV_W +: COV_W];
          exp_f = exp_val[k*COV_W +: COV_W];
          if (got_f !== exp_f) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_N) begin
              $display("[%0t] %s expected %0d actual %0d", $realtime, cov_name[k],
                       exp_f, got_f);
            end
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Directed table, then random Gaussians, then drain and report.
  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    m_tready = 1'b0;

    // Zero quaternion gives the identity rotation.
    directed_rows.push_back('{mk_gauss(65536, 65536, 65536, 0, 0, 0, 0), 1'b1,
                              cov_result_t'({C_ONE, 48'd0, C_ONE, 48'd0, 48'd0, C_ONE})});
    directed_rows.push_back('{mk_gauss(0, 0, 0, 32767, 32767, 32767, 32767), 1'b1,
                              cov_result_t'('0)});
    directed_rows.push_back('{mk_gauss(8388607, 8388607, 8388607, 0, 0, 0, 0), 1'b1,
                              cov_result_t'({C_BIG, 48'd0, C_BIG, 48'd0, 48'd0, C_BIG})});
    directed_rows.push_back('{mk_gauss(-8388608, -8388608, -8388608, 0, 0, 0, 0), 1'b1,
                              cov_result_t'({C_NEG, 48'd0, C_NEG, 48'd0, 48'd0, C_NEG})});
    // Largest quaternion with largest scales saturates both ways.
    directed_rows.push_back('{mk_gauss(-8388608, -8388608, -8388608,
                                       -32768, -32768, -32768, -32768), 1'b1,
                              cov_result_t'({C_MAX, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX})});
    directed_rows.push_back('{mk_gauss(8388607, 8388607, 8388607,
                                       -32768, -32768, -32768, -32768), 1'b0, '0});
    directed_rows.push_back('{mk_gauss(8388607, -8388608, 1,
                                       32767, -32768, 32767, -32768), 1'b0, '0});
    directed_rows.push_back('{mk_gauss(-8388608, 8388607, -1,
                                       32767, 32767, 32767, 32767), 1'b0, '0});
    // Rounding exactly at one half, positive and negative.
    directed_rows.push_back('{mk_gauss(3, 1, 5, 0, 16384, 0, 0), 1'b0, '0});
    directed_rows.push_back('{mk_gauss(-3, -1, -5, 0, 16384, 0, 0), 1'b0, '0});
    // Scales of mixed sign, then the same Gaussian with every scale sign flipped.
    directed_rows.push_back('{mk_gauss(196608, -131072, 40000, 12000, -7000, 3000, 30000),
                              1'b0, '0});
    directed_rows.push_back('{mk_gauss(-196608, 131072, -40000, 12000, -7000, 3000, 30000),
                              1'b0, '0});
    // Single-component quaternions.
    directed_rows.push_back('{mk_gauss(65536, 131072, 196608, 32767, 0, 0, 0), 1'b0, '0});
    directed_rows.push_back('{mk_gauss(65536, 131072, 196608, 0, -32768, 0, 0), 1'b0, '0});
    directed_rows.push_back('{mk_gauss(65536, 131072, 196608, 0, 0, 32767, 0), 1'b0, '0});
    directed_rows.push_back('{mk_gauss(65536, 131072, 196608, 0, 0, 0, 32767), 1'b0, '0});
    // Nearly unit quaternion, a quarter turn about z.
    directed_rows.push_back('{mk_gauss(65536, 131072, 196608, 0, 0, 23170, 23170),
                              1'b0, '0});

    repeat (6) @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      send_gaussian(directed_rows[i].item,
                    directed_rows[i].typed ? directed_rows[i].exp
                                           : covariance_of(directed_rows[i].item));
    end

    repeat (RANDOM_N) begin
      gauss_t g;
      g = rand_gaussian();
      send_gaussian(g, covariance_of(g));
    end
    s_tvalid <= 1'b0;

    // Drain the pipeline, then let it idle before the report.
    while (pending_cov.size() != 0) @(posedge clk);
    repeat (DRAIN_LEN) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
